// ===== rtl/core/ebcr_pkg.sv =====
// Shared constants, types and state codes for the edge-timing bit clock recovery core.
package ebcr_pkg;

    localparam int TIME_W      = 32;              // timer width, even, 16..32
    localparam int ACC_W       = 32;              // window bounds are formed modulo 2^32
    localparam int MAX_BIT_RUN = 8;               // longest run of equal bits tested
    localparam int K_W         = $clog2(MAX_BIT_RUN + 1);
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int DIV_STEPS   = TIME_W / 2;      // two quotient bits per cycle
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_NOM_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOM_MARGIN = 1'd1;

    localparam logic [CFG_W-1:0] NOM_PERIOD_RST = 24'd33333;
    localparam logic [CFG_W-1:0] NOM_MARGIN_RST = 24'd3333;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVIDE,
        ST_DONE
    } ebcr_state_t;

    typedef struct packed {
        logic           done;
        logic [K_W-1:0] matched;
    } ebcr_win_stat_t;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } ebcr_div_stat_t;

endpackage

// ===== rtl/core/ebcr_window.sv =====
// Serial window test: one accumulate and bounds compare per run length k.
module ebcr_window
    import ebcr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] diff,
    input  logic [CFG_W-1:0]  nom_period,
    input  logic [CFG_W-1:0]  nom_margin,
    output ebcr_win_stat_t    stat
);

    logic             busy_reg,    busy_next;
    logic             done_reg,    done_next;
    logic [K_W-1:0]   k_reg,       k_next;
    logic [K_W-1:0]   matched_reg, matched_next;
    logic [ACC_W-1:0] lo_reg,      lo_next;
    logic [ACC_W-1:0] hi_reg,      hi_next;
    logic [ACC_W-1:0] step_lo;
    logic [ACC_W-1:0] step_hi;
    logic [ACC_W-1:0] diff_ext;
    logic             hit;

    // k * bound mod 2^32 built up by repeated addition
    assign step_lo  = ACC_W'(nom_period) - ACC_W'(nom_margin);
    assign step_hi  = ACC_W'(nom_period) + ACC_W'(nom_margin);
    assign diff_ext = ACC_W'(diff);
    assign hit      = (lo_reg < diff_ext) && (diff_ext < hi_reg);

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        k_next       = k_reg;
        matched_next = matched_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        if (start) begin
            busy_next    = 1'b1;
            k_next       = K_W'(1);
            matched_next = '0;
            lo_next      = step_lo;
            hi_next      = step_hi;
        end else if (busy_reg) begin
            // no early exit: the largest matching k wins
            if (hit) begin
                matched_next = k_reg;
            end
            if (k_reg == K_W'(MAX_BIT_RUN)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                k_next  = k_reg + K_W'(1);
                lo_next = lo_reg + step_lo;
                hi_next = hi_reg + step_hi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        k_reg       <= k_next;
        matched_reg <= matched_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
    end

    assign stat.done    = done_reg;
    assign stat.matched = matched_reg;

endmodule

// ===== rtl/core/ebcr_div.sv =====
// Serial restoring divider by a small run length, two quotient bits per cycle.
module ebcr_div
    import ebcr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [K_W-1:0]    divisor,
    output ebcr_div_stat_t    stat
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [TIME_W-1:0]    quo_reg,  quo_next;
    logic [K_W-1:0]       rem_reg,  rem_next;
    logic [K_W-1:0]       dvs_reg,  dvs_next;
    logic [TIME_W-1:0]    q_step;
    logic [K_W-1:0]       r_step;
    logic [K_W:0]         part;

    // two dependent shift-subtract steps on a narrow remainder
    always_comb begin
        q_step = quo_reg;
        r_step = rem_reg;
        part   = '0;
        for (int i = 0; i < 2; i++) begin
            part   = {r_step, q_step[TIME_W-1]};
            q_step = {q_step[TIME_W-2:0], 1'b0};
            if (part >= {1'b0, dvs_reg}) begin
                part      = part - {1'b0, dvs_reg};
                q_step[0] = 1'b1;
            end
            r_step = part[K_W-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = q_step;
            rem_next = r_step;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ===== rtl/core/edge_timing_bit_clock_recovery_core.sv =====
// Top level: edge sequencer, bit clock state, config registers and output register.
// Path: a compare item or early edge goes to the done state, then the output register;
//   other edges scan (8 window steps) and, if matched, divide (16 steps at 2 bits each).
// Throughput: one item at a time, s_tready only while the sequencer is idle; the
//   window scan, the serial divider and m_tready back-pressure set the per-item time.
// Reset (aresetn low, synchronous): no edges seen, period and compare time zero,
//   registers back to period 33333 and margin 3333; no clearing pass.
module edge_timing_bit_clock_recovery_core
    import ebcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] edge_time
    input  logic [0:0]           s_tuser,   // [0] action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // [31:0] compare_time, [35:32] bits_matched,
                                            // [67:36] bit_period, [71:68] zero
    output logic [0:0]           m_tuser,   // [0] compare_written
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    ebcr_state_t       state_reg, state_next;
    logic [CFG_W-1:0]  sym_period_reg;
    logic [CFG_W-1:0]  sym_margin_reg;
    logic [TIME_W-1:0] last_rise_reg;
    logic [TIME_W-1:0] last_fall_reg;
    logic              rise_seen_reg;
    logic              fall_seen_reg;
    logic              expect_rise_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] compare_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] diff_reg;
    logic              written_reg;
    logic [K_W-1:0]    matched_reg;
    logic              m_tvalid_reg;
    logic [71:0]       m_tdata_reg;
    logic [0:0]        m_tuser_reg;

    logic              accept;
    logic [TIME_W-1:0] edge_t;
    logic [TIME_W-1:0] edge_diff;
    logic              both_seen;
    logic              win_start;
    logic              div_start;
    logic              out_load;
    ebcr_win_stat_t    win_stat;
    ebcr_div_stat_t    div_stat;

    assign accept    = s_tvalid && s_tready;
    assign edge_t    = s_tdata[TIME_W-1:0];
    assign edge_diff = expect_rise_reg ? (edge_t - last_fall_reg) : (edge_t - last_rise_reg);
    // the opposite edge kind decides, this edge marks its own kind seen
    assign both_seen = expect_rise_reg ? fall_seen_reg : rise_seen_reg;

    ebcr_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (win_start),
        .diff       (diff_reg),
        .nom_period (sym_period_reg),
        .nom_margin (sym_margin_reg),
        .stat       (win_stat)
    );

    ebcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (win_stat.matched),
        .stat     (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        win_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0] || !both_seen) begin
                        state_next = ST_DONE;
                    end else begin
                        win_start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (win_stat.done) begin
                    if (win_stat.matched != '0) begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_period_reg  <= NOM_PERIOD_RST;
            sym_margin_reg  <= NOM_MARGIN_RST;
            last_rise_reg   <= '0;
            last_fall_reg   <= '0;
            rise_seen_reg   <= 1'b0;
            fall_seen_reg   <= 1'b0;
            expect_rise_reg <= 1'b1;
            period_reg      <= '0;
            compare_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_NOM_PERIOD: sym_period_reg <= cfg_wdata;
                    REG_NOM_MARGIN: sym_margin_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept && s_tuser[0]) begin
                compare_reg <= compare_reg + period_reg;
            end else if (accept) begin
                if (expect_rise_reg) begin
                    last_rise_reg <= edge_t;
                    rise_seen_reg <= 1'b1;
                end else begin
                    last_fall_reg <= edge_t;
                    fall_seen_reg <= 1'b1;
                end
                expect_rise_reg <= !expect_rise_reg;
            end
            if (div_stat.done) begin
                period_reg  <= div_stat.quotient;
                compare_reg <= time_reg + div_stat.quotient;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        if (accept) begin
            time_reg    <= edge_t;
            diff_reg    <= edge_diff;
            written_reg <= s_tuser[0];
            matched_reg <= '0;
        end
        if (state_reg == ST_SCAN && win_stat.done) begin
            matched_reg <= win_stat.matched;
        end
        if (div_stat.done) begin
            written_reg <= 1'b1;
        end
        if (out_load) begin
            m_tdata_reg    <= {4'd0, 32'(period_reg), 4'(matched_reg), 32'(compare_reg)};
            m_tuser_reg[0] <= written_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after taking an item");

    a_win_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        win_stat.done |-> state_reg == ST_SCAN)
        else $error("window scan finished outside the scan state");

    a_div_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide state");

    a_match_implies_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35:32] != 4'd0 |-> m_tuser[0])
        else $error("matched run without a compare write");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !m_tvalid_reg || m_tready)
        else $error("result overwritten before it was taken");

endmodule

// ===== tb/tb_edge_timing_bit_clock_recovery_core.sv =====
// Self-checking testbench for the edge-timing bit clock recovery core.
module tb_edge_timing_bit_clock_recovery_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ebcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 32;    // idle wait after the last result is back

    typedef struct packed {
        logic              is_compare;
        logic [TIME_W-1:0] stamp;
    } edge_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] cmp_time;
        logic              written;
        logic [3:0]        bits;
        logic [TIME_W-1:0] per;
    } recovery_out_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [71:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NOM_PERIOD;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    edge_timing_bit_clock_recovery_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // register copies
    logic [CFG_W-1:0]  sym_period = NOM_PERIOD_RST;
    logic [CFG_W-1:0]  sym_margin = NOM_MARGIN_RST;

    // recovered-clock state
    logic [TIME_W-1:0] rise_stamp   = '0;
    logic [TIME_W-1:0] fall_stamp   = '0;
    logic              rise_valid   = 1'b0;
    logic              fall_valid   = 1'b0;
    logic              next_is_rise = 1'b1;
    logic [TIME_W-1:0] bit_len      = '0;
    logic [TIME_W-1:0] cmp_time     = '0;

    edge_item_t        pending_items[$];
    recovery_out_t     expected_results[$];
    logic [TIME_W-1:0] edge_cursor = '0;

    int unsigned drv_count   = 0;
    int unsigned acc_count   = 0;
    int unsigned mismatches  = 0;
    int unsigned quiet_count = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;
    logic        idle_on     = 1'b1;
    edge_item_t  next_item;
    recovery_out_t got, want;

    function automatic recovery_out_t recover_bit_clock(input logic is_cmp,
                                                        input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] interval;
        logic [31:0]       hi_b;
        logic [31:0]       lo_b;
        logic [3:0]        best;
        recovery_out_t     r;
        best      = '0;
        interval  = '0;
        r.written = 1'b0;
        if (is_cmp) begin
            cmp_time  = cmp_time + bit_len;
            r.written = 1'b1;
        end else begin
            if (next_is_rise) begin
                rise_stamp   = t;
                rise_valid   = 1'b1;
                next_is_rise = 1'b0;
                interval     = rise_stamp - fall_stamp;
            end else begin
                fall_stamp   = t;
                fall_valid   = 1'b1;
                next_is_rise = 1'b1;
                interval     = fall_stamp - rise_stamp;
            end
            if (rise_valid && fall_valid) begin
                // no early exit: the longest matching run wins
                for (int k = 1; k <= MAX_BIT_RUN; k++) begin
                    hi_b = ({8'd0, sym_period} + {8'd0, sym_margin}) * 32'(k);
                    lo_b = ({8'd0, sym_period} - {8'd0, sym_margin}) * 32'(k);
                    if (lo_b < interval && interval < hi_b)
                        best = 4'(k);
                end
                if (best != 0) begin
                    bit_len   = interval / 32'(best);
                    cmp_time  = t + bit_len;
                    r.written = 1'b1;
                end
            end
        end
        r.cmp_time = cmp_time;
        r.bits     = best;
        r.per      = bit_len;
        return r;
    endfunction

    // item driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || acc_count == drv_count)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 && idle_on && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                next_item = pending_items.pop_front();
                s_tdata  <= next_item.stamp;
                s_tuser  <= next_item.is_compare;
                s_tvalid <= 1'b1;
                drv_count++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result-side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // acceptance, prediction, checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_count++;
            if (s_tvalid && s_tready) begin
                acc_count++;
                quiet_count = 0;
                expected_results.push_back(recover_bit_clock(s_tuser[0], s_tdata));
            end
            if (m_tvalid && m_tready) begin
                quiet_count = 0;
                got.cmp_time = m_tdata[31:0];
                got.bits     = m_tdata[35:32];
                got.per      = m_tdata[67:36];
                got.written  = m_tuser[0];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: cmp=%h wr=%b bits=%0d per=%h",
                                 got.cmp_time, got.written, got.bits, got.per);
                end else begin
                    want = expected_results.pop_front();
                    if (got.cmp_time !== want.cmp_time || got.written !== want.written ||
                        got.bits !== want.bits || got.per !== want.per) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp cmp=%h wr=%b bits=%0d per=%h,",
                                      " got cmp=%h wr=%b bits=%0d per=%h"},
                                     want.cmp_time, want.written, want.bits, want.per,
                                     got.cmp_time, got.written, got.bits, got.per);
                    end
                end
            end
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic queue_edge(input logic [TIME_W-1:0] t);
        pending_items.push_back('{is_compare: 1'b0, stamp: t});
        edge_cursor = t;
    endtask

    task automatic queue_compare();
        pending_items.push_back('{is_compare: 1'b1, stamp: $urandom});
    endtask

    // interval aimed at a random run length: mostly inside a window, some on its edges, some random
    function automatic logic [TIME_W-1:0] pick_interval();
        longint unsigned k, span, base;
        int unsigned     mode;
        k    = $urandom_range(1, MAX_BIT_RUN);
        base = k * sym_period;
        span = k * sym_margin;
        mode = $urandom_range(0, 9);
        if (mode < 6 && span > 0)
            return 32'(base - span + 1 + $urandom_range(0, 32'(2 * span - 2)));
        if (mode < 8) begin
            case ($urandom_range(0, 3))
                0:       return 32'(base - span);
                1:       return 32'(base - span + 1);
                2:       return 32'(base + span - 1);
                default: return 32'(base + span);
            endcase
        end
        if (mode == 8)
            return $urandom_range(0, 10 * sym_period);
        return $urandom;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_NOM_PERIOD)
            sym_period = val;
        else
            sym_margin = val;
    endtask

    // hold the sender until every result is back and the core has settled
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || drv_count != acc_count ||
               expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] per, input logic [CFG_W-1:0] mar);
        drain();
        write_reg(REG_NOM_PERIOD, per);
        write_reg(REG_NOM_MARGIN, mar);
    endtask

    task automatic run_random(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    queue_compare();
                2:       queue_edge($urandom);           // breaks the edge train
                default: queue_edge(edge_cursor + pick_interval());
            endcase
        end
    endtask

    initial begin
        logic [CFG_W-1:0] per;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset timing 33333 +- 3333
        queue_compare();                         // period still zero
        queue_edge(32'hFFFF_FFF0);               // first edge: stored only
        queue_compare();
        queue_edge(32'hFFFF_FFF0 + 32'd33333);   // one bit, compare time wraps
        queue_compare();
        queue_compare();
        queue_edge(edge_cursor + 3 * 33333 + 100);
        queue_edge(edge_cursor + 8 * 33333);
        queue_edge(edge_cursor + 5);             // no window
        queue_compare();
        queue_edge(edge_cursor + 60000);         // exactly on the lower bound
        queue_edge(edge_cursor + 60001);
        queue_edge(edge_cursor + 73332);         // exactly on the upper bound
        queue_edge(edge_cursor + 73331);
        queue_edge(32'h0000_0000);
        queue_edge(32'hFFFF_FFFF);

        // margin above period: lower bound wraps
        set_timing(24'd100, 24'd300);
        queue_edge(edge_cursor + 350);
        queue_edge(edge_cursor - 100);
        // margin equal to period: lower bound zero
        set_timing(24'd50, 24'd50);
        queue_edge(edge_cursor + 120);
        queue_edge(edge_cursor + 1);
        queue_compare();
        // zero period
        set_timing(24'd0, 24'd10);
        queue_edge(edge_cursor + 5);
        queue_compare();
        set_timing(24'd1, 24'd0);
        queue_edge(edge_cursor + 1);
        set_timing(24'hFF_FFFF, 24'hFF_FFFF);
        queue_edge(edge_cursor + 32'd200_000_000);
        queue_edge(edge_cursor + 32'd40_000_000);

        set_timing(24'd33333, 24'd3333);
        run_random(130);
        set_timing(24'd1000, 24'd100);
        run_random(130);
        set_timing(24'hFF_FFFF, 24'd0);
        run_random(80);
        set_timing(24'hFF_FFFF, 24'h7F_FFFF);
        run_random(80);
        for (int p = 0; p < 3; p++) begin
            per = CFG_W'($urandom_range(10, 5000));
            set_timing(per, CFG_W'($urandom_range(0, per / 3)));
            run_random(130);
        end
        set_timing(24'd7, 24'd3);
        run_random(80);

        // final stretch without idling on either side
        per = CFG_W'($urandom_range(10, 5000));
        set_timing(per, CFG_W'($urandom_range(0, per / 3)));
        idle_on = 1'b0;
        run_random(150);
        drain();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ebcr_pkg.sv
rtl/core/ebcr_window.sv
rtl/core/ebcr_div.sv
rtl/core/edge_timing_bit_clock_recovery_core.sv
tb/tb_edge_timing_bit_clock_recovery_core.sv
